### hw/rtl/r2y_pkg.sv
// shared types, constants and helpers for the rgb24 to yuv420 converter
// no dependencies
`default_nettype none

package r2y_pkg;

	localparam int MAX_DIM = 4096;
	localparam int CNT_W   = $clog2(MAX_DIM);
	localparam int DIM_W   = 13;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd720;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1280;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_U    = 2'd1,
		KIND_V    = 2'd2
	} chroma_kind_t;

	typedef struct packed {
		logic row_end;
		logic frame_end;
		logic chroma_on;
		logic odd_row;
	} pos_t;

	typedef struct packed {
		logic [7:0]   luma;
		logic [7:0]   chroma;
		chroma_kind_t kind;
	} color_t;

	// last index of a dimension, with 0 read as 1 and large values clamped
	function automatic logic [CNT_W-1:0] last_index(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] d;
		begin
			if (v == '0) begin
				d = DIM_W'(1);
			end else if (v > DIM_W'(MAX_DIM)) begin
				d = DIM_W'(MAX_DIM);
			end else begin
				d = v;
			end
			last_index = CNT_W'(d - DIM_W'(1));
		end
	endfunction

endpackage

`default_nettype wire

### hw/rtl/r2y_position.sv
// frame size registers and raster column / row counters
// depends on r2y_pkg
`default_nettype none

module r2y_position import r2y_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire logic                 step,
	output pos_t                      pos
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		pos.row_end   = col_q >= last_index(width_q);
		pos.frame_end = pos.row_end && (row_q >= last_index(height_q));
		pos.chroma_on = !col_q[0];
		pos.odd_row   = row_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (pos.row_end) begin
				col_q <= '0;
				row_q <= pos.frame_end ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/r2y_color.sv
// fixed-point rgb to y / u / v arithmetic for one pixel
// depends on r2y_pkg
`default_nettype none

module r2y_color import r2y_pkg::*; (
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	input  wire pos_t       pos,
	output color_t          color
);

	logic        [16:0] y_sum;
	logic signed [17:0] r_s;
	logic signed [17:0] g_s;
	logic signed [17:0] b_s;
	logic signed [17:0] c_sum;

	always_comb begin
		y_sum = 17'({9'd0, red}) * 17'd76 + 17'({9'd0, green}) * 17'd150
			+ 17'({9'd0, blue}) * 17'd29;
		r_s = $signed({10'd0, red});
		g_s = $signed({10'd0, green});
		b_s = $signed({10'd0, blue});
		if (pos.odd_row) begin
			c_sum = r_s * 18'sd131 - g_s * 18'sd110 - b_s * 18'sd21;
		end else begin
			c_sum = b_s * 18'sd131 - r_s * 18'sd44 - g_s * 18'sd87;
		end
		color.luma = y_sum[15:8];
		if (pos.chroma_on) begin
			// floor shift by 8 then offset, wrapping at 8 bits
			color.chroma = c_sum[15:8] + 8'd128;
			color.kind   = pos.odd_row ? KIND_V : KIND_U;
		end else begin
			color.chroma = '0;
			color.kind   = KIND_NONE;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/rgb24_to_yuv420_pixel_converter.sv
// rgb24 to yuv420 converter top level: input register, color math, result register
// result path: the input register holds the pixel, the color math reads it, the result register drives m_tvalid
// throughput 1 pixel per cycle while m_tready stays high, set by the input register and the result register
// the input stage takes a new pixel while a result waits, as long as that stage is free
// reset: counters cleared, frame size 720 x 1280, both stages empty
// depends on r2y_pkg, r2y_position, r2y_color
`default_nettype none

module rgb24_to_yuv420_pixel_converter import r2y_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [23:0]          s_tdata,   // red, green, blue
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [15:0]               m_tdata,   // luma, chroma
	output logic [2:0]                m_tuser,   // chroma_kind, row_end
	output logic                      m_tlast,   // frame_end
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data
);

	logic        s_xfer;
	logic        adv_s1;
	pos_t        pos;
	logic        valid_s1;
	logic [23:0] rgb_s1;
	pos_t        pos_s1;
	color_t      color;
	logic        valid_s2;
	color_t      color_s2;
	pos_t        pos_s2;

	assign cfg_ready = 1'b1;
	assign adv_s1    = !valid_s2 || m_tready;
	assign s_tready  = !valid_s1 || adv_s1;
	assign s_xfer    = s_tvalid && s_tready;

	r2y_position u_position (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (s_xfer),
		.pos       (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			rgb_s1 <= s_tdata;
			pos_s1 <= pos;
		end
	end

	r2y_color u_color (
		.red   (rgb_s1[7:0]),
		.green (rgb_s1[15:8]),
		.blue  (rgb_s1[23:16]),
		.pos   (pos_s1),
		.color (color)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			color_s2 <= color;
			pos_s2   <= pos_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {color_s2.chroma, color_s2.luma};
	assign m_tuser  = {pos_s2.row_end, color_s2.kind};
	assign m_tlast  = pos_s2.frame_end;

endmodule

`default_nettype wire

### verif/r2y_checker.sv
// checker for the rgb24 to yuv420 converter: watches the config, pixel and result channels,
// predicts each result from the configured frame size and compares it with what arrives
// depends on r2y_pkg
`timescale 1ns / 1ps

module r2y_checker import r2y_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [23:0]          s_tdata,   // red, green, blue
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [15:0]          m_tdata,   // luma, chroma
	input  wire logic [2:0]           m_tuser,   // chroma_kind, row_end
	input  wire logic                 m_tlast,   // frame_end
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	output int                        errors,
	output int                        pending,
	output int                        pixels_seen,
	output int                        frames_seen
);

	typedef struct packed {
		logic [7:0]   luma;
		logic [7:0]   chroma;
		chroma_kind_t kind;
		logic         row_end;
		logic         frame_end;
	} yuv_t;

	yuv_t             yuv_queue[$];
	logic [DIM_W-1:0] width_reg  = WIDTH_RESET;
	logic [DIM_W-1:0] height_reg = HEIGHT_RESET;
	int               col_idx    = 0;
	int               row_idx    = 0;
	int               err_count  = 0;
	int               pix_count  = 0;
	int               frame_total = 0;

	assign errors      = err_count;
	assign pending     = yuv_queue.size();
	assign pixels_seen = pix_count;
	assign frames_seen = frame_total;

	// last usable index of a dimension, zero reads as one and oversize clamps
	function automatic int last_of(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			return 0;
		end else if (int'(v) > MAX_DIM) begin
			return MAX_DIM - 1;
		end
		return int'(v) - 1;
	endfunction

	function automatic yuv_t predict_yuv(input logic [23:0] rgb, input int col, input int row,
			input int col_last, input int row_last);
		yuv_t y;
		int   r, g, b, c;
		r = int'(rgb[7:0]);
		g = int'(rgb[15:8]);
		b = int'(rgb[23:16]);
		y.luma = 8'((76 * r + 150 * g + 29 * b) >>> 8);
		y.chroma = '0;
		y.kind = KIND_NONE;
		if (col[0] == 1'b0) begin
			if (row[0] == 1'b0) begin
				c = ((-44 * r - 87 * g + 131 * b) >>> 8) + 128;
				y.kind = KIND_U;
			end else begin
				c = ((131 * r - 110 * g - 21 * b) >>> 8) + 128;
				y.kind = KIND_V;
			end
			y.chroma = c[7:0];
		end
		y.row_end = (col >= col_last);
		y.frame_end = y.row_end && (row >= row_last);
		return y;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		yuv_t want, got;
		if (!arst_n) begin
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			col_idx = 0;
			row_idx = 0;
			yuv_queue.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got.luma = m_tdata[7:0];
				got.chroma = m_tdata[15:8];
				got.kind = chroma_kind_t'(m_tuser[1:0]);
				got.row_end = m_tuser[2];
				got.frame_end = m_tlast;
				pix_count++;
				if (m_tlast) begin
					frame_total++;
				end
				if (yuv_queue.size() == 0) begin
					err_count++;
					if (err_count <= 10) begin
						$display("%0t: unexpected result: y %0d c %0d k %0d re %0d fe %0d",
							$time, got.luma, got.chroma, got.kind, got.row_end,
							got.frame_end);
					end
				end else begin
					want = yuv_queue.pop_front();
					if (got !== want) begin
						err_count++;
						if (err_count <= 10) begin
							$display("%0t: result %0d expected y %0d c %0d k %0d re %0d fe %0d",
								$time, pix_count, want.luma, want.chroma, want.kind,
								want.row_end, want.frame_end);
							$display("%0t: result %0d      got y %0d c %0d k %0d re %0d fe %0d",
								$time, pix_count, got.luma, got.chroma, got.kind,
								got.row_end, got.frame_end);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want = predict_yuv(s_tdata, col_idx, row_idx, last_of(width_reg),
					last_of(height_reg));
				yuv_queue.push_back(want);
				if (want.row_end) begin
					col_idx = 0;
					row_idx = want.frame_end ? 0 : row_idx + 1;
				end else begin
					col_idx++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_WIDTH: begin
						width_reg = cfg_data;
					end
					REG_FRAME_HEIGHT: begin
						height_reg = cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

### verif/tb.sv
// testbench top for the rgb24 to yuv420 converter: clock, reset, pixel and size stimulus
// under several idle and stall mixes; checking is done by r2y_checker
// depends on r2y_pkg, r2y_checker and the converter rtl
`timescale 1ns / 1ps

module tb;
	import r2y_pkg::*;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	wire                  s_tready;
	logic [23:0]          s_tdata   = '0;    // red, green, blue
	wire                  m_tvalid;
	logic                 m_tready  = 1'b0;
	wire  [15:0]          m_tdata;           // luma, chroma
	wire  [2:0]           m_tuser;           // chroma_kind, row_end
	wire                  m_tlast;           // frame_end
	logic                 cfg_valid = 1'b0;
	wire                  cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [DIM_W-1:0]     cfg_data  = '0;

	int src_idle   = 0;
	int sink_stall = 0;
	int errors;
	int pending;
	int pixels_seen;
	int frames_seen;

	rgb24_to_yuv420_pixel_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	r2y_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.pending     (pending),
		.pixels_seen (pixels_seen),
		.frames_seen (frames_seen)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall);
	end

	initial begin
		#2000000;
		$display("tb NOT OK");
		$finish;
	end

	// saturated primaries and secondaries plus black and white
	function automatic logic [23:0] corner_color(input int i);
		case (i)
			0: return 24'h000000;
			1: return 24'hffffff;
			2: return 24'h0000ff;
			3: return 24'h00ff00;
			4: return 24'hff0000;
			5: return 24'h00ffff;
			6: return 24'hffff00;
			default: return 24'hff00ff;
		endcase
	endfunction

	function automatic logic [7:0] rand_component();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// {height, width} per segment; includes zero, one, max and oversize values
	function automatic logic [2*DIM_W-1:0] segment_size(input int k);
		case (k)
			0: return {13'd2, 13'd2};
			1: return {13'd4096, 13'd4096};
			2: return {13'd3, 13'd5};
			3: return {13'd0, 13'd0};
			4: return {13'd4096, 13'd1};
			5: return {13'd2, 13'd7};
			6: return {13'd8191, 13'd8191};
			default: return {13'($urandom_range(9, 1)), 13'($urandom_range(16, 1))};
		endcase
	endfunction

	// called and returns at a falling edge
	task automatic send_pixel(input logic [23:0] rgb);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rgb;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		cfg_valid <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [2*DIM_W-1:0] sz;
		int                 mode;
		int                 seg;
		int                 n;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset frame size
		for (n = 0; n < 4; n++) begin
			send_pixel(corner_color(n));
		end

		// one column: every pixel carries chroma, rows alternate between u and v
		wait_idle();
		write_size(13'd1, 13'd4);
		for (n = 0; n < 16; n++) begin
			send_pixel(corner_color(n / 2));
		end

		for (mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin
					src_idle = 0;
					sink_stall = 0;
				end
				1: begin
					src_idle = 86;
					sink_stall = 0;
				end
				2: begin
					src_idle = 0;
					sink_stall = 86;
				end
				default: begin
					src_idle = 24;
					sink_stall = 24;
				end
			endcase
			for (seg = 0; seg < 2; seg++) begin
				// size changes can land mid-row and mid-frame
				wait_idle();
				sz = segment_size(mode * 2 + seg);
				write_size(sz[DIM_W-1:0], sz[2*DIM_W-1:DIM_W]);
				repeat (50) begin
					send_pixel({rand_component(), rand_component(), rand_component()});
				end
			end
		end

		wait_idle();
		$display("%0d pixels converted, %0d frames closed, frame sizes from 0x0 to 8191x8191",
			pixels_seen, frames_seen);
		$display("traffic ran free, with sparse input, with heavy output stall and with both");
		if (errors == 0 && pending == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
